// ===== design/segill_pkg.sv =====
// Shared types, constants and table functions for the seasonal epidemic stepper.
// Used by the divider, datapath, controller and top level; depends on nothing.
package segill_pkg;

  localparam int CW        = 16;          // compartment count width
  localparam int NW        = CW + 3;      // width of a sum of five counts
  localparam int TF        = 20;          // time fraction bits
  localparam int PHW       = 29;          // year phase width
  localparam int LOG_DEPTH = 1024;
  localparam int LOG_AW    = $clog2(LOG_DEPTH);
  localparam int NL_W      = 28;          // -ln table entry width, Q.24
  localparam int DIV_NW    = NL_W + TF;   // divider dividend / quotient width
  localparam int RW        = 64;          // cumulative rate width
  localparam int IN_W      = 144;
  localparam int OUT_W     = 120;
  localparam int CFG_IW    = 3;

  localparam logic [PHW-1:0] YEAR_T  = PHW'(64'd365 << TF);
  localparam logic [31:0]    VACC_T  = 32'(64'd730 << TF);
  localparam logic [31:0]    END_T   = 32'(64'd2920 << TF);
  localparam logic [63:0]    LN2_Q32 = 64'd2977044472;

  localparam logic [CFG_IW-1:0] CFG_BIRTH  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_DEATH  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_TRANS  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_NVACC  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_VDAY   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_MATURE = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_RECOV  = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SEASON = 3'd7;

  typedef enum logic [3:0] {
    EV_BIRTH, EV_DEATH_S, EV_DEATH_SV, EV_DEATH_IP, EV_DEATH_V, EV_DEATH_P,
    EV_INF_S, EV_INF_SV, EV_MATURE, EV_RECOVER, EV_SEASON_ON, EV_SEASON_OFF,
    EV_VACC, EV_NONE
  } event_e;

  typedef enum logic [1:0] {FX_SEASON_ON, FX_SEASON_OFF, FX_VACC} fixed_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP1, S_PREP2, S_SUM1, S_SUM2, S_SUM3, S_RCHK, S_DTDIV, S_DTWAIT,
    S_DTEVAL, S_PICK1, S_PICK2, S_CLASS, S_VDIV, S_VWAIT, S_COMMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic prep1;
    logic prep2;
    logic sum1;
    logic sum2;
    logic sum3;
    logic div_dt;
    logic div_vac;
    logic eval;
    logic pick1;
    logic pick2;
    logic classify;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic rate_zero;
    logic vacc;
    logic dt_short;
    logic div_busy;
    logic out_free;
  } status_t;

  typedef logic [NL_W-1:0] neglog_tbl_t [LOG_DEPTH];

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [CW-1:0] sat_dec(input logic [CW-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

  // log2 in Q.24 by repeated squaring of the normalized mantissa.
  function automatic logic [31:0] log2_q24(input logic [31:0] n);
    logic [65:0] m;
    logic [4:0]  p;
    logic [23:0] frac;
    p = '0;
    frac = '0;
    for (int i = 1; i < 32; i++) begin
      if ((n >> i) != 0) p = 5'(i);
    end
    m = ({34'd0, n} << 31) >> p;
    for (int j = 0; j < 24; j++) begin
      m = (m * m) >> 31;
      frac = {frac[22:0], 1'b0};
      if (m >= (66'd1 << 32)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return {3'd0, p, frac};
  endfunction

  function automatic neglog_tbl_t build_neglog();
    neglog_tbl_t t;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] diff;
    a = {32'd0, log2_q24(32'(2 * LOG_DEPTH))};
    for (int k = 0; k < LOG_DEPTH; k++) begin
      b = {32'd0, log2_q24(32'(2 * k + 1))};
      diff = (a > b) ? a - b : 64'd0;
      t[k] = NL_W'((diff * LN2_Q32) >> 32);
    end
    return t;
  endfunction

  localparam neglog_tbl_t NEGLOG_TBL = build_neglog();

endpackage

// ===== design/segill_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the waiting-time
// and vaccination divisions. Depends on segill_pkg.
module segill_div import segill_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] dividend_i,
  input  logic [RW-1:0]     divisor_i,
  output logic              busy_o,
  output logic [DIV_NW-1:0] quotient_o
);

  localparam int CNTW = $clog2(DIV_NW + 1);

  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [RW-1:0]     dvs_q, dvs_d;
  logic [RW:0]       trial;

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    trial = {rem_q, quo_q[DIV_NW-1]};
    if (start_i) begin
      cnt_d = CNTW'(DIV_NW);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      // The dividend shifts out at the top while quotient bits enter below.
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = RW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[DIV_NW-2:0], 1'b1};
      end else begin
        rem_d = trial[RW-1:0];
        quo_d = {quo_q[DIV_NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

// ===== design/segill_dp.sv =====
// Datapath: configuration, simulation state, rate products and sums, the -ln
// table, event choice and the output register. Depends on segill_pkg, segill_div.
module segill_dp import segill_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [IN_W-1:0]   in_data_i,
  input  logic              in_op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_W-1:0]  res_data_o
);

  // Configuration
  logic [31:0]    birth_q, death_q, trans_q, mature_q, recov_q;
  logic [CW-1:0]  nvacc_q;
  logic [PHW-1:0] vday_q, season_q;

  // Simulation state
  logic [31:0]    time_q;
  logic [PHW-1:0] phase_q;
  logic           breed_q, done_q;
  logic [CW-1:0]  cs_q, csv_q, cip_q, cv_q, cp_q;

  // Captured item
  logic           op_q;
  logic [31:0]    rp_q, rt_q, rv_q;
  logic [CW-1:0]  is_q, ii_q, ir_q;

  // Working registers
  logic [NL_W-1:0]  nl_q;
  logic [NW-1:0]    n_q;
  logic [2*CW-1:0]  pis_q, pisv_q;
  logic [47:0]      gv_q, gp_q;
  logic [PHW-1:0]   wmin_q;
  fixed_e           which_q;
  logic [63:0]      bp1_q, bp2_q;
  logic [50:0]      dn_q;
  logic [NW-1:0]    vic_q;
  logic [2*CW+1:0]  vnum_q;
  logic [NW:0]      vden_q;
  logic [RW-1:0]    c1_q, c2_q, c3_q, c4_q, rate_q, x34_q, y_q;
  logic [63:0]      phi_q, plo_q;
  logic [RW-1:0]    pick_q;
  event_e           ev_q;
  logic             drawn_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_q;

  logic              div_busy;
  logic [DIV_NW-1:0] quo;
  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [RW-1:0]     div_den;

  logic [RW-1:0] c0;
  assign c0 = breed_q ? {32'd0, birth_q} : '0;

  // Next fixed-time event: year start (season on), season end, vaccination day.
  logic [PHW-1:0] w_d;
  fixed_e         which_d;
  always_comb begin
    w_d = YEAR_T - phase_q;
    which_d = FX_SEASON_ON;
    if (phase_q < season_q && (season_q - phase_q) < w_d) begin
      w_d = season_q - phase_q;
      which_d = FX_SEASON_OFF;
    end
    if (phase_q < vday_q && (vday_q - phase_q) < w_d) begin
      w_d = vday_q - phase_q;
      which_d = FX_VACC;
    end
  end

  logic [NW-1:0] nn;
  assign nn = (n_q == '0) ? NW'(1) : n_q;

  // Event classification from the pick and the victim draw.
  logic [NW-1:0] v1, v2, v3, v4;
  event_e        ev_d;
  assign v1 = NW'(cs_q);
  assign v2 = v1 + NW'(csv_q);
  assign v3 = v2 + NW'(cip_q);
  assign v4 = v3 + NW'(cv_q);
  always_comb begin
    if (pick_q < c0)        ev_d = EV_BIRTH;
    else if (pick_q < c1_q) begin
      if (vic_q < v1)       ev_d = EV_DEATH_S;
      else if (vic_q < v2)  ev_d = EV_DEATH_SV;
      else if (vic_q < v3)  ev_d = EV_DEATH_IP;
      else if (vic_q < v4)  ev_d = EV_DEATH_V;
      else                  ev_d = EV_DEATH_P;
    end
    else if (pick_q < c2_q) ev_d = EV_INF_S;
    else if (pick_q < c3_q) ev_d = EV_INF_SV;
    else if (pick_q < c4_q) ev_d = EV_MATURE;
    else                    ev_d = EV_RECOVER;
  end

  // Commit: next state and result.
  logic [CW-1:0]  s_d, sv_d, ip_d, v_d, p_d, amt;
  logic [CW:0]    sv_sum;
  logic [31:0]    time_d;
  logic [PHW-1:0] phase_d, delta;
  logic [32:0]    t_sum;
  logic [PHW:0]   p_sum;
  logic           breed_d, done_d, adv;
  event_e         evo;

  always_comb begin
    s_d = cs_q;
    sv_d = csv_q;
    ip_d = cip_q;
    v_d = cv_q;
    p_d = cp_q;
    breed_d = breed_q;
    evo = EV_NONE;
    delta = '0;
    adv = 1'b0;
    amt = (quo > DIV_NW'(cs_q)) ? cs_q : quo[CW-1:0];
    if (time_q <= VACC_T) amt = '0;
    sv_sum = {1'b0, csv_q} + {1'b0, amt};
    if (op_q && !done_q) begin
      adv = 1'b1;
      if (drawn_q) begin
        delta = quo[PHW-1:0];
        evo = ev_q;
        case (ev_q)
          EV_BIRTH:    s_d = sat_inc(cs_q);
          EV_DEATH_S:  s_d = sat_dec(cs_q);
          EV_DEATH_SV: sv_d = sat_dec(csv_q);
          EV_DEATH_IP: ip_d = sat_dec(cip_q);
          EV_DEATH_V:  v_d = sat_dec(cv_q);
          EV_DEATH_P:  p_d = sat_dec(cp_q);
          EV_INF_S: begin
            s_d = sat_dec(cs_q);
            ip_d = sat_inc(cip_q);
          end
          EV_INF_SV: begin
            sv_d = sat_dec(csv_q);
            ip_d = sat_inc(cip_q);
          end
          EV_MATURE: begin
            sv_d = sat_dec(csv_q);
            v_d = sat_inc(cv_q);
          end
          EV_RECOVER: begin
            ip_d = sat_dec(cip_q);
            p_d = sat_inc(cp_q);
          end
          default: ;
        endcase
      end else begin
        delta = wmin_q + 1'b1;
        case (which_q)
          FX_SEASON_ON: begin
            breed_d = 1'b1;
            evo = EV_SEASON_ON;
          end
          FX_SEASON_OFF: begin
            breed_d = 1'b0;
            evo = EV_SEASON_OFF;
          end
          default: begin
            s_d = cs_q - amt;
            sv_d = sv_sum[CW] ? '1 : sv_sum[CW-1:0];
            evo = EV_VACC;
          end
        endcase
      end
    end
    t_sum = {1'b0, time_q} + {4'd0, delta};
    p_sum = {1'b0, phase_q} + {1'b0, delta};
    if (p_sum >= {1'b0, YEAR_T}) p_sum = p_sum - {1'b0, YEAR_T};
    time_d = t_sum[32] ? '1 : t_sum[31:0];
    phase_d = p_sum[PHW-1:0];
    done_d = done_q;
    if (adv) done_d = (time_d >= END_T) || (ip_d == '0);
    if (!op_q) begin
      s_d = is_q;
      ip_d = ii_q;
      p_d = ir_q;
      sv_d = '0;
      v_d = '0;
      time_d = '0;
      phase_d = '0;
      breed_d = (season_q != '0);
      done_d = (ii_q == '0);
    end
  end

  // Divider sharing
  assign div_start = cmd_i.div_dt | cmd_i.div_vac;
  assign div_num = cmd_i.div_vac ? DIV_NW'(vnum_q)
                 : ((rt_q == '0) ? '0 : {nl_q, {TF{1'b0}}});
  assign div_den = cmd_i.div_vac ? RW'(vden_q) : rate_q;

  segill_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i) begin
    nl_q <= NEGLOG_TBL[rt_q[31 -: LOG_AW]];
    if (cmd_i.capture) begin
      op_q <= in_op_i;
      rp_q <= in_data_i[31:0];
      rt_q <= in_data_i[63:32];
      rv_q <= in_data_i[95:64];
      is_q <= in_data_i[111:96];
      ii_q <= in_data_i[127:112];
      ir_q <= in_data_i[143:128];
    end
    if (cmd_i.prep1) begin
      n_q <= NW'(cs_q) + NW'(csv_q) + NW'(cip_q) + NW'(cv_q) + NW'(cp_q);
      pis_q <= (2*CW)'(cip_q) * (2*CW)'(cs_q);
      pisv_q <= (2*CW)'(cip_q) * (2*CW)'(csv_q);
      gv_q <= 48'(mature_q) * 48'(csv_q);
      gp_q <= 48'(recov_q) * 48'(cip_q);
      wmin_q <= w_d;
      which_q <= which_d;
    end
    if (cmd_i.prep2) begin
      bp1_q <= {32'd0, trans_q} * {32'd0, pis_q};
      bp2_q <= {32'd0, trans_q} * {32'd0, pisv_q};
      dn_q <= 51'(death_q) * 51'(n_q);
      vic_q <= NW'((51'(rv_q) * 51'(n_q)) >> 32);
      vnum_q <= (2*CW+2)'({(2*CW)'(nvacc_q) * (2*CW)'(cs_q), 1'b0}) + (2*CW+2)'(nn);
      vden_q <= {nn, 1'b0};
    end
    if (cmd_i.sum1) begin
      c1_q <= c0 + RW'(dn_q);
      x34_q <= RW'(bp2_q >> 8) + RW'(gv_q);
    end
    if (cmd_i.sum2) begin
      c2_q <= c1_q + RW'(bp1_q >> 8);
      y_q <= x34_q + RW'(gp_q);
    end
    if (cmd_i.sum3) begin
      c3_q <= c2_q + RW'(bp2_q >> 8);
      c4_q <= c2_q + x34_q;
      rate_q <= c2_q + y_q;
    end
    if (cmd_i.pick1) begin
      phi_q <= {32'd0, rate_q[63:32]} * {32'd0, rp_q};
      plo_q <= {32'd0, rate_q[31:0]} * {32'd0, rp_q};
    end
    if (cmd_i.pick2) pick_q <= phi_q + (plo_q >> 32);
    if (cmd_i.classify) ev_q <= ev_d;
    if (cmd_i.commit) begin
      out_q <= {3'd0, done_d, evo, p_d, v_d, ip_d, sv_d, s_d, time_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q <= '0;
      death_q <= '0;
      trans_q <= '0;
      nvacc_q <= '0;
      vday_q <= '0;
      mature_q <= 32'd1174405;
      recov_q <= '0;
      season_q <= '0;
      time_q <= '0;
      phase_q <= '0;
      breed_q <= 1'b0;
      done_q <= 1'b1;
      cs_q <= '0;
      csv_q <= '0;
      cip_q <= '0;
      cv_q <= '0;
      cp_q <= '0;
      drawn_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BIRTH:  birth_q <= cfg_data_i;
          CFG_DEATH:  death_q <= cfg_data_i;
          CFG_TRANS:  trans_q <= cfg_data_i;
          CFG_NVACC:  nvacc_q <= cfg_data_i[CW-1:0];
          CFG_VDAY:   vday_q <= cfg_data_i[PHW-1:0];
          CFG_MATURE: mature_q <= cfg_data_i;
          CFG_RECOV:  recov_q <= cfg_data_i;
          CFG_SEASON: season_q <= cfg_data_i[PHW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.prep1) drawn_q <= 1'b0;
      if (cmd_i.eval) drawn_q <= status_o.dt_short;
      if (cmd_i.commit) begin
        time_q <= time_d;
        phase_q <= phase_d;
        breed_q <= breed_d;
        done_q <= done_d;
        cs_q <= s_d;
        csv_q <= sv_d;
        cip_q <= ip_d;
        cv_q <= v_d;
        cp_q <= p_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.skip      = !op_q || done_q;
  assign status_o.rate_zero = (rate_q == '0);
  assign status_o.vacc      = (which_q == FX_VACC);
  assign status_o.dt_short  = (quo < DIV_NW'(wmin_q));
  assign status_o.div_busy  = div_busy;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign res_data_o  = out_q;

`ifndef ASSERT_OFF
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over an untaken result");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < YEAR_T)
    else $error("year phase out of range");
  a_live_infected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_q |-> (cip_q != '0))
    else $error("trial running with no infected");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== design/segill_ctrl.sv =====
// Controller state machine: sequences capture, rate build-up, divisions,
// event choice and commit. Depends on segill_pkg.
module segill_ctrl import segill_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_PREP1;
        end
      end
      S_PREP1: begin
        cmd_o.prep1 = 1'b1;
        // Loads and steps after the end go straight to commit.
        state_d = status_i.skip ? S_COMMIT : S_PREP2;
      end
      S_PREP2: begin
        cmd_o.prep2 = 1'b1;
        state_d = S_SUM1;
      end
      S_SUM1: begin
        cmd_o.sum1 = 1'b1;
        state_d = S_SUM2;
      end
      S_SUM2: begin
        cmd_o.sum2 = 1'b1;
        state_d = S_SUM3;
      end
      S_SUM3: begin
        cmd_o.sum3 = 1'b1;
        state_d = S_RCHK;
      end
      S_RCHK: begin
        if (!status_i.rate_zero) state_d = S_DTDIV;
        else if (status_i.vacc)  state_d = S_VDIV;
        else                     state_d = S_COMMIT;
      end
      S_DTDIV: begin
        cmd_o.div_dt = 1'b1;
        state_d = S_DTWAIT;
      end
      S_DTWAIT: begin
        if (!status_i.div_busy) state_d = S_DTEVAL;
      end
      S_DTEVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.dt_short)  state_d = S_PICK1;
        else if (status_i.vacc) state_d = S_VDIV;
        else                    state_d = S_COMMIT;
      end
      S_PICK1: begin
        cmd_o.pick1 = 1'b1;
        state_d = S_PICK2;
      end
      S_PICK2: begin
        cmd_o.pick2 = 1'b1;
        state_d = S_CLASS;
      end
      S_CLASS: begin
        cmd_o.classify = 1'b1;
        state_d = S_COMMIT;
      end
      S_VDIV: begin
        cmd_o.div_vac = 1'b1;
        state_d = S_VWAIT;
      end
      S_VWAIT: begin
        if (!status_i.div_busy) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== design/seasonal_epidemic_gillespie_step_top.sv =====
// Top level of the seasonal epidemic stepper: controller plus datapath.
// Depends on segill_pkg, segill_ctrl, segill_dp (and segill_div below it).
//
// Usage: configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i while the block is idle. Each input transfer on the s_axis side
// carries either a load (tuser 0: initial counts, restart of the trial) or a
// step (tuser 1: three uniform random words). Every input transfer yields
// exactly one output transfer on the m_axis side with the time, the five
// counts, the event code and the finished flag.
// A load, or a step after the trial ended, goes straight to commit; a step at zero
// total rate skips the waiting-time division. A normal step runs the bit-serial
// divider for the waiting time and then either draws a random event or takes the
// fixed-time event when that wins; a vaccination runs the divider again for the dose count.
// One item is in work at a time; a new input is taken once the previous result
// sits in the output register, so a stalled receiver holds only that register,
// and the next item waits at commit until it is taken.
// Reset clears the trial state (finished set, all counts zero) and returns
// the configuration registers to their defaults.
module seasonal_epidemic_gillespie_step_top import segill_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // rand_pick, rand_time, rand_victim, init_susceptible, init_infected,
  // init_recovered
  input  logic [IN_W-1:0]   s_axis_tdata,
  // op
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // sim_time, susceptible, vaccine_infected, infected, vaccinated, recovered,
  // event_res, finished, zero fill
  output logic [OUT_W-1:0]  m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  segill_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  segill_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata)
  );

endmodule

// ===== tb/seasonal_epidemic_gillespie_step_top_test.sv =====
// Self-checking testbench for the seasonal epidemic Gillespie stepper.
// Depends on segill_pkg and seasonal_epidemic_gillespie_step_top; drives random and
// directed load/step transfers and checks every result against its own trial predictor.
module seasonal_epidemic_gillespie_step_top_test import segill_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PAUSE_CYCLES = 150;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          ITEM_GOAL    = 1350;
  localparam logic [63:0] YEAR_LEN     = 64'd365 << TF;
  localparam logic [63:0] VACC_START   = 64'd730 << TF;
  localparam logic [63:0] TRIAL_END    = 64'd2920 << TF;
  localparam logic [63:0] LN2_FRAC     = 64'd2977044472;
  localparam logic [31:0] DAY_LIMIT    = 32'd382730240;
  localparam bit          OP_LOAD      = 1'b0;
  localparam bit          OP_STEP      = 1'b1;

  typedef struct {
    bit        op;
    bit [31:0] pick;
    bit [31:0] wait_frac;
    bit [31:0] victim;
    bit [15:0] init_s;
    bit [15:0] init_ip;
    bit [15:0] init_p;
  } trial_item_t;

  typedef struct {
    bit [31:0] sim_t;
    bit [15:0] s;
    bit [15:0] sv;
    bit [15:0] ip;
    bit [15:0] v;
    bit [15:0] p;
    event_e    ev;
    bit        fin;
  } trial_state_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_idx = '0;
  logic [31:0]      cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [IN_W-1:0]  in_data = '0;
  logic             in_op = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OUT_W-1:0] res_bus;

  seasonal_epidemic_gillespie_step_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
    .s_axis_tdata(in_data), .s_axis_tuser(in_op),
    .m_axis_tvalid(out_valid), .m_axis_tready(out_ready), .m_axis_tdata(res_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: configuration copy and trial state.
  bit [31:0] birth_peak, death_r, trans_r, vacc_doses, vacc_day, mature_r, recov_r, season_len;
  bit [63:0] now_t, phase_t, n_s, n_sv, n_ip, n_v, n_p;
  bit        breeding, trial_done;
  bit [63:0] neglog_q24 [LOG_DEPTH];

  trial_item_t  item_q[$];
  trial_state_t expected_q[$];
  int  errors = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  int  offered_cnt = 0;
  int  accepted_cnt = 0;
  int  send_gap = 0;
  int  stall_left = 0;

  function automatic bit [63:0] log2_fixed(input bit [31:0] n);
    bit [63:0] m;
    bit [63:0] frac;
    int        p;
    p = 0;
    frac = 0;
    while (p < 31 && (n >> (p + 1)) != 0) p++;
    m = ({32'd0, n} << 31) >> p;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    return (64'(p) << 24) | frac;
  endfunction

  function automatic bit [63:0] pair_rate(input bit [63:0] y);
    bit [63:0] hi;
    bit [63:0] lo;
    hi = 64'(trans_r >> 16);
    lo = 64'(trans_r & 32'hFFFF);
    return ((hi * y) << 8) + ((lo * y) >> 8);
  endfunction

  function automatic bit [63:0] bump(input bit [63:0] c);
    return (c < 64'hFFFF) ? c + 1 : c;
  endfunction

  function automatic bit [63:0] drop(input bit [63:0] c);
    return (c > 0) ? c - 1 : 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IW-1:0] idx, input bit [31:0] val);
    case (idx)
      CFG_BIRTH:  birth_peak = val;
      CFG_DEATH:  death_r = val;
      CFG_TRANS:  trans_r = val;
      CFG_NVACC:  vacc_doses = val & 32'hFFFF;
      CFG_VDAY:   vacc_day = val & 32'h1FFFFFFF;
      CFG_MATURE: mature_r = val;
      CFG_RECOV:  recov_r = val;
      CFG_SEASON: season_len = val & 32'h1FFFFFFF;
      default: ;
    endcase
  endfunction

  // Advances the trial by one load or step transfer and returns the visible state.
  function automatic trial_state_t advance_trial(input trial_item_t it);
    trial_state_t r;
    event_e       ev;
    fixed_e       which;
    bit [63:0]    n, c0, c1, c2, c3, c4, rate, wmin, dt, delta, nl, pick, vic, nn, amt;
    bit           drawn;
    ev = EV_NONE;
    if (it.op == OP_LOAD) begin
      n_s = 64'(it.init_s);
      n_ip = 64'(it.init_ip);
      n_p = 64'(it.init_p);
      n_sv = 0;
      n_v = 0;
      now_t = 0;
      phase_t = 0;
      breeding = season_len > 0;
      trial_done = n_ip == 0;
    end else if (!trial_done) begin
      n = n_s + n_sv + n_ip + n_v + n_p;
      c0 = breeding ? 64'(birth_peak) : 0;
      c1 = c0 + 64'(death_r) * n;
      c2 = c1 + pair_rate(n_ip * n_s);
      c3 = c2 + pair_rate(n_ip * n_sv);
      c4 = c3 + 64'(mature_r) * n_sv;
      rate = c4 + 64'(recov_r) * n_ip;
      wmin = YEAR_LEN - phase_t;
      which = FX_SEASON_ON;
      if (phase_t < season_len && season_len - phase_t < wmin) begin
        wmin = season_len - phase_t;
        which = FX_SEASON_OFF;
      end
      if (phase_t < vacc_day && vacc_day - phase_t < wmin) begin
        wmin = vacc_day - phase_t;
        which = FX_VACC;
      end
      drawn = 1'b0;
      dt = 0;
      if (rate != 0) begin
        nl = (it.wait_frac != 0) ? neglog_q24[it.wait_frac[31 -: LOG_AW]] : 0;
        dt = (nl << TF) / rate;
        drawn = dt < wmin;
      end
      if (drawn) begin
        pick = (rate >> 32) * it.pick + (((rate & 64'hFFFFFFFF) * it.pick) >> 32);
        if (pick < c0) begin
          n_s = bump(n_s); ev = EV_BIRTH;
        end else if (pick < c1) begin
          vic = (64'(it.victim) * n) >> 32;
          if (vic < n_s) begin
            n_s = drop(n_s); ev = EV_DEATH_S;
          end else if (vic < n_s + n_sv) begin
            n_sv = drop(n_sv); ev = EV_DEATH_SV;
          end else if (vic < n_s + n_sv + n_ip) begin
            n_ip = drop(n_ip); ev = EV_DEATH_IP;
          end else if (vic < n_s + n_sv + n_ip + n_v) begin
            n_v = drop(n_v); ev = EV_DEATH_V;
          end else begin
            n_p = drop(n_p); ev = EV_DEATH_P;
          end
        end else if (pick < c2) begin
          n_s = drop(n_s); n_ip = bump(n_ip); ev = EV_INF_S;
        end else if (pick < c3) begin
          n_sv = drop(n_sv); n_ip = bump(n_ip); ev = EV_INF_SV;
        end else if (pick < c4) begin
          n_sv = drop(n_sv); n_v = bump(n_v); ev = EV_MATURE;
        end else begin
          n_ip = drop(n_ip); n_p = bump(n_p); ev = EV_RECOVER;
        end
        delta = dt;
      end else begin
        if (which == FX_SEASON_ON) begin
          breeding = 1'b1; ev = EV_SEASON_ON;
        end else if (which == FX_SEASON_OFF) begin
          breeding = 1'b0; ev = EV_SEASON_OFF;
        end else begin
          nn = (n > 0) ? n : 1;
          amt = (2 * 64'(vacc_doses) * n_s + nn) / (2 * nn);
          if (amt > n_s) amt = n_s;
          if (now_t <= VACC_START) amt = 0;
          n_s = n_s - amt;
          n_sv = (n_sv + amt > 64'hFFFF) ? 64'hFFFF : n_sv + amt;
          ev = EV_VACC;
        end
        delta = wmin + 1;
      end
      now_t = (now_t + delta > 64'hFFFFFFFF) ? 64'hFFFFFFFF : now_t + delta;
      phase_t = phase_t + delta;
      if (phase_t >= YEAR_LEN) phase_t = phase_t - YEAR_LEN;
      trial_done = (now_t >= TRIAL_END) || n_ip == 0;
    end
    r.sim_t = now_t[31:0];
    r.s = n_s[15:0];
    r.sv = n_sv[15:0];
    r.ip = n_ip[15:0];
    r.v = n_v[15:0];
    r.p = n_p[15:0];
    r.ev = ev;
    r.fin = trial_done;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input bit [63:0] got, input bit [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Sender: a transfer is seen at the rising edge and the next item is put up at the falling one.
  always @(negedge clk_i) begin
    if (in_valid && offered_cnt != accepted_cnt) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (item_q.size() > 0) begin
      trial_item_t it;
      it = item_q.pop_front();
      offered_cnt++;
      in_data <= {it.init_p, it.init_ip, it.init_s, it.victim, it.wait_frac, it.pick};
      in_op <= it.op;
      send_gap = pick_gap();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    trial_item_t  it;
    trial_state_t want;
    trial_state_t got;
    if (in_valid && in_ready && rst_ni) begin
      it.op = in_op;
      {it.init_p, it.init_ip, it.init_s, it.victim, it.wait_frac, it.pick} = in_data;
      expected_q.push_back(advance_trial(it));
      accepted_cnt++;
    end
    if (out_valid && out_ready && rst_ni) begin
      got.sim_t = res_bus[31:0];
      got.s = res_bus[47:32];
      got.sv = res_bus[63:48];
      got.ip = res_bus[79:64];
      got.v = res_bus[95:80];
      got.p = res_bus[111:96];
      got.ev = event_e'(res_bus[115:112]);
      got.fin = res_bus[116];
      if (expected_q.size() == 0) begin
        $display("result transfer with nothing expected at %0t", $realtime);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.sim_t != want.sim_t) report_mismatch("sim_time", got.sim_t, want.sim_t);
        if (got.s != want.s) report_mismatch("susceptible", got.s, want.s);
        if (got.sv != want.sv) report_mismatch("vaccine_infected", got.sv, want.sv);
        if (got.ip != want.ip) report_mismatch("infected", got.ip, want.ip);
        if (got.v != want.v) report_mismatch("vaccinated", got.v, want.v);
        if (got.p != want.p) report_mismatch("recovered", got.p, want.p);
        if (got.ev != want.ev) report_mismatch("event_res", got.ev, want.ev);
        if (got.fin != want.fin) report_mismatch("finished", got.fin, want.fin);
        if (res_bus[119:117] != '0) report_mismatch("zero fill", res_bus[119:117], 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_item(input bit op, input bit [31:0] pk, input bit [31:0] wt,
                           input bit [31:0] vc, input bit [15:0] s0, input bit [15:0] i0,
                           input bit [15:0] p0);
    trial_item_t it;
    it.op = op; it.pick = pk; it.wait_frac = wt; it.victim = vc;
    it.init_s = s0; it.init_ip = i0; it.init_p = p0;
    item_q.push_back(it);
    items_sent++;
  endtask

  function automatic bit [15:0] rand_count();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return 16'($urandom);
    if (r == 2) return 0;
    return 16'($urandom_range(1, 60));
  endfunction

  task automatic push_load();
    push_item(OP_LOAD, $urandom, $urandom, $urandom, rand_count(), rand_count(), rand_count());
  endtask

  task automatic push_step();
    bit [31:0] wt;
    int        r;
    r = $urandom_range(0, 19);
    wt = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFFFFFF : $urandom;
    push_item(OP_STEP, $urandom, wt, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    while (item_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input bit [31:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [31:0] rand_rate(input int kind);
    int r;
    if (kind == 1) return 32'hFFFFFFFF;
    if (kind == 2) return 0;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return $urandom;
    return $urandom_range(0, 1 << 20);
  endfunction

  function automatic bit [31:0] rand_day(input int kind);
    int r;
    if (kind == 1) return DAY_LIMIT;
    if (kind == 2) return 0;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return DAY_LIMIT;
    return $urandom_range(0, DAY_LIMIT);
  endfunction

  // kind 1 sets every register to its top value, kind 2 clears them, kind 3 keeps only
  // the calendar and the dose count so the trial runs on fixed-time events alone.
  task automatic configure(input int kind);
    int rk;
    rk = (kind == 3) ? 2 : kind;
    write_reg(CFG_BIRTH, rand_rate(rk));
    write_reg(CFG_DEATH, rand_rate(rk));
    write_reg(CFG_TRANS, (rk == 0) ? $urandom_range(0, 1 << 26) : rand_rate(rk));
    write_reg(CFG_NVACC, (kind == 1) ? 32'hFFFF : (kind == 2) ? 0 : $urandom_range(0, 65535));
    write_reg(CFG_VDAY, (kind == 3) ? rand_day(0) : rand_day(kind));
    write_reg(CFG_MATURE, rand_rate(rk));
    write_reg(CFG_RECOV, rand_rate(rk));
    write_reg(CFG_SEASON, (kind == 3) ? rand_day(0) : rand_day(kind));
  endtask

  initial begin
    bit [63:0] top_log;
    bit [63:0] entry_log;
    int        phase_no;
    int        phase_end;
    for (int k = 0; k < LOG_DEPTH; k++) begin
      top_log = log2_fixed(32'(2 * LOG_DEPTH));
      entry_log = log2_fixed(32'(2 * k + 1));
      neglog_q24[k] = ((top_log > entry_log ? top_log - entry_log : 0) * LN2_FRAC) >> 32;
    end
    birth_peak = 0; death_r = 0; trans_r = 0; vacc_doses = 0; vacc_day = 0;
    mature_r = 32'd1174405; recov_r = 0; season_len = 0;
    now_t = 0; phase_t = 0; breeding = 0; trial_done = 1;
    n_s = 0; n_sv = 0; n_ip = 0; n_v = 0; n_p = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: step while finished after reset, loads at the count extremes,
    // zero and full waiting-time words, zero total rate, and a load with no infected.
    push_item(OP_STEP, 0, 0, 0, 0, 0, 0);
    push_item(OP_LOAD, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(OP_STEP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0);
    push_item(OP_STEP, 0, 0, 0, 0, 0, 0);
    push_item(OP_LOAD, 0, 0, 0, 0, 0, 0);
    push_item(OP_STEP, 1, 1, 1, 0, 0, 0);
    drain();
    repeat (PAUSE_CYCLES) @(posedge clk_i);
    configure(1);
    push_item(OP_LOAD, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(OP_STEP, 0, 32'hFFFFFFFF, 0, 0, 0, 0);
    push_item(OP_STEP, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 0, 0, 0);
    push_item(OP_STEP, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0);
    push_item(OP_LOAD, 0, 0, 0, 3, 1, 0);
    for (int i = 0; i < 6; i++) push_step();

    phase_no = 0;
    while (items_sent < ITEM_GOAL) begin
      drain();
      repeat (PAUSE_CYCLES) @(posedge clk_i);
      calm = (phase_no % 5 == 4);
      configure(phase_no == 1 ? 2 : (phase_no % 3 == 0) ? 3 : 0);
      push_load();
      phase_end = items_sent + $urandom_range(30, 60);
      while (items_sent < phase_end) begin
        drain();
        if (trial_done && $urandom_range(0, 3) != 0) push_load();
        for (int i = 0; i < 8; i++) begin
          if ($urandom_range(0, 24) == 0) push_load();
          else push_step();
        end
      end
      phase_no++;
    end

    drain();
    repeat (PAUSE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== seasonal_epidemic_gillespie_step_top.f =====
design/segill_pkg.sv
design/segill_div.sv
design/segill_dp.sv
design/segill_ctrl.sv
design/seasonal_epidemic_gillespie_step_top.sv
tb/seasonal_epidemic_gillespie_step_top_test.sv
